FILE: hw/rtl/sms_pkg.sv
// Shared types and constants for the substring match splitter.
// Holds the transaction structs, the configuration register map and default sizes.
// No dependencies.
package sms_pkg;

	localparam int PATTERN_BYTES       = 16;
	localparam int PATTERN_LEN_W       = 5;
	localparam int START_W             = 16;
	localparam int CFG_DATA_W          = 64;
	localparam int CFG_INDEX_W         = 2;
	localparam int DEF_MAX_PATTERN_LEN = 16;
	localparam int DEF_MAX_TEXT_LEN    = 65536;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2,
		CFG_SPLIT_MODE     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0]    pattern_low_bytes;
		logic [CFG_DATA_W-1:0]    pattern_high_bytes;
		logic [PATTERN_LEN_W-1:0] pattern_length;
		logic                     split_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic               match_hit;
		logic [START_W-1:0] match_start;
		logic               end_of_text;
		logic               none_found;
	} out_item_t;

endpackage

FILE: hw/rtl/substring_match_splitter.sv
// Substring match splitter: takes one text byte per cycle unless result_ready holds it
// back, and compares the newest bytes against a configured pattern of up to 16 bytes.
// Each accepted byte yields exactly one result transaction, passing the input register
// and then the result register; a new byte can be accepted every cycle unless the
// result register is full and not being emptied. No clearing pass follows reset.
module substring_match_splitter import sms_pkg::*; #(
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int MAX_TEXT_LEN    = DEF_MAX_TEXT_LEN
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  in_item_t               text_item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output out_item_t              result_item,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_next;
	out_item_t result_q;
	logic      result_valid_q;
	logic      advance;
	logic      text_fire;

	sms_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sms_match_core #(
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN),
		.MAX_TEXT_LEN    (MAX_TEXT_LEN)
	) u_match_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result_next)
	);

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign text_ready = !valid_s1 || advance;
	assign text_fire  = text_valid && text_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= text_fire || (valid_s1 && !advance);
			result_valid_q <= advance || (result_valid_q && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (text_fire) begin
			item_s1 <= text_item;
		end
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

FILE: hw/rtl/sms_cfg_regs.sv
// Configuration register file of the substring match splitter.
// Decodes the plain write port into the cfg_t bundle; uses sms_pkg.
module sms_cfg_regs import sms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LOW: begin
					cfg_q.pattern_low_bytes <= cfg_wdata;
				end
				CFG_PATTERN_HIGH: begin
					cfg_q.pattern_high_bytes <= cfg_wdata;
				end
				CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_wdata[PATTERN_LEN_W-1:0];
				end
				CFG_SPLIT_MODE: begin
					cfg_q.split_mode <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/sms_match_core.sv
// Byte window, text counters and parallel pattern compare of the splitter.
// Produces the result for the byte in the input stage and updates state on advance.
// Uses sms_pkg for the transaction and configuration types.
module sms_match_core import sms_pkg::*; #(
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int MAX_TEXT_LEN    = DEF_MAX_TEXT_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  item,
	input  logic      advance,
	output out_item_t result
);

	localparam int BW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int PW = $clog2(MAX_TEXT_LEN + 1);
	localparam int CW = (BW > PATTERN_LEN_W) ? BW : PATTERN_LEN_W;
	localparam int IW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int SW = (PW > START_W) ? PW : START_W;

	logic [7:0]    window_q    [MAX_PATTERN_LEN];
	logic [7:0]    window_next [MAX_PATTERN_LEN];
	logic [7:0]    pat         [MAX_PATTERN_LEN];
	logic [CW-1:0] pidx        [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0] eq;

	logic [PW-1:0] pos_q, pos_inc;
	logic [BW-1:0] since_q, since_inc;
	logic          any_q;

	logic [CW-1:0] len_c;
	logic [SW-1:0] start_w;
	logic          len_ok, pos_ok, enough, mode_ok, hit;
	logic [2*CFG_DATA_W-1:0] pattern_all;

	assign pattern_all = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

	// Pattern positions past the sixteen configured bytes compare against zero.
	for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_pat
		if (k < PATTERN_BYTES) begin : g_cfg
			assign pat[k] = pattern_all[8*k +: 8];
		end else begin : g_zero
			assign pat[k] = 8'h00;
		end
	end

	always_comb begin
		window_next[0] = item.text_byte;
		for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
			window_next[i] = window_q[i-1];
		end
	end

	assign len_c = CW'(cfg.pattern_length);

	// Window entry j (newest first) lines up with pattern byte len-1-j.
	always_comb begin
		for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
			pidx[j] = len_c - CW'(1) - CW'(j);
			eq[j]   = (CW'(j) >= len_c) || (window_next[j] == pat[pidx[j][IW-1:0]]);
		end
	end

	assign len_ok    = (len_c != '0) && (len_c <= CW'(MAX_PATTERN_LEN));
	assign pos_ok    = pos_q < PW'(MAX_TEXT_LEN);
	assign since_inc = (since_q < BW'(MAX_PATTERN_LEN)) ? since_q + BW'(1) : since_q;
	assign pos_inc   = pos_ok ? pos_q + PW'(1) : pos_q;
	assign enough    = CW'(since_inc) >= len_c;
	assign mode_ok   = cfg.split_mode || !any_q;
	assign hit       = len_ok && pos_ok && enough && mode_ok && (&eq);
	assign start_w   = SW'(pos_q) + SW'(1) - SW'(cfg.pattern_length);

	always_comb begin
		result.match_hit   = hit;
		result.match_start = hit ? start_w[START_W-1:0] : '0;
		result.end_of_text = item.is_last;
		result.none_found  = item.is_last && !(any_q || hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			since_q <= '0;
			any_q   <= 1'b0;
		end else if (advance) begin
			if (item.is_last) begin
				pos_q   <= '0;
				since_q <= '0;
				any_q   <= 1'b0;
			end else begin
				pos_q   <= pos_inc;
				since_q <= hit ? '0 : since_inc;
				any_q   <= any_q || hit;
			end
		end
	end

	// The window needs no clearing: a compare only looks at bytes taken since the
	// start of the text or the last match, which the byte counter guarantees.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				window_q[i] <= window_next[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_any_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit && !item.is_last |=> any_q)
		else $error("match seen flag not set after a hit");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.is_last |=> (pos_q == '0) && (since_q == '0) && !any_q)
		else $error("text state not cleared after the final byte");

	a_search_single: assert property (@(posedge clk) disable iff (!arst_n)
		any_q && !cfg.split_mode |-> !hit)
		else $error("second match reported in search mode");

	a_hit_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> CW'(since_inc) >= len_c && len_c != '0)
		else $error("match overlaps the previous one");
`endif

endmodule
